// File: sv/rppd_pkg.sv
// Package for the rotor position pulse detector.
// Holds codes, reset values, vector tables and controller/datapath structs.
// No dependencies.
package rppd_pkg;

  localparam int VOTES_DEF        = 10;
  localparam int CURRENT_BITS_DEF = 12;
  localparam int OUT_W            = 64;
  localparam int ADDR_W           = 4;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] REG_PWM_PERIOD    = 2'd0;
  localparam logic [1:0] REG_DUTY_FRACTION = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS    = 2'd2;

  localparam logic [15:0] PWM_PERIOD_RST    = 16'd500;
  localparam logic [15:0] DUTY_FRACTION_RST = 16'd6554;
  localparam logic [15:0] HOLD_TICKS_RST    = 16'd16;

  localparam logic [2:0] VEC_OFF  = 3'd0;
  localparam logic [2:0] VEC_ONE  = 3'd1;
  localparam logic [2:0] VEC_LAST = 3'd6;
  localparam logic [2:0] VEC_ALT  = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic pat;
    logic cnt_step;
    logic judge;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pat_req;
    logic last_vote;
    logic cnt_last;
  } stat_t;

  // phase-high mask per vector, bit0 A, bit1 B, bit2 C
  function automatic logic [2:0] vec_mask(input logic [2:0] v);
    case (v)
      3'd1:    vec_mask = 3'd1;
      3'd2:    vec_mask = 3'd3;
      3'd3:    vec_mask = 3'd2;
      3'd4:    vec_mask = 3'd6;
      3'd5:    vec_mask = 3'd4;
      3'd6:    vec_mask = 3'd5;
      3'd7:    vec_mask = 3'd1;
      default: vec_mask = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] vec_next(input logic [2:0] v);
    case (v)
      3'd1:    vec_next = 3'd4;
      3'd2:    vec_next = 3'd5;
      3'd3:    vec_next = 3'd6;
      3'd4:    vec_next = 3'd2;
      3'd5:    vec_next = 3'd3;
      3'd6:    vec_next = 3'd1;
      3'd7:    vec_next = 3'd4;
      default: vec_next = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] vec_slot(input logic [2:0] v);
    case (v)
      3'd2:    vec_slot = 3'd2;
      3'd3:    vec_slot = 3'd4;
      3'd4:    vec_slot = 3'd1;
      3'd5:    vec_slot = 3'd3;
      3'd6:    vec_slot = 3'd5;
      default: vec_slot = 3'd0;
    endcase
  endfunction

  // 0 A, 1 B, 2 C
  function automatic logic [1:0] vec_phase(input logic [2:0] v);
    case (v)
      3'd2:    vec_phase = 2'd2;
      3'd3:    vec_phase = 2'd1;
      3'd5:    vec_phase = 2'd2;
      3'd6:    vec_phase = 2'd1;
      default: vec_phase = 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] pat_sector(input logic [2:0] p);
    case (p)
      3'd0:    pat_sector = 3'd4;
      3'd1:    pat_sector = 3'd5;
      3'd4:    pat_sector = 3'd3;
      3'd6:    pat_sector = 3'd2;
      3'd7:    pat_sector = 3'd1;
      default: pat_sector = 3'd0;
    endcase
  endfunction

  function automatic logic pat_ok(input logic [2:0] p);
    pat_ok = (p != 3'd2) && (p != 3'd5);
  endfunction

endpackage

// File: sv/rotor_position_pulse_detector.sv
// Rotor position pulse detector, top level: APB registers, controller, datapath.
// After a word is accepted, STEP runs for every word; a tick that closes a vote also passes
// PAT, and one that fills the vote store goes on through COUNT (one vote entry counted
// per cycle) and JUDGE; OUT registers the result once the output is free. One word in flight.
// Reset: synchronous, active high; registers return to 500/6554/16, detection stopped.
// Uses rppd_pkg, rppd_ctrl and rppd_datapath.
module rotor_position_pulse_detector #(
  parameter int VOTES        = rppd_pkg::VOTES_DEF,
  parameter int CURRENT_BITS = rppd_pkg::CURRENT_BITS_DEF,
  parameter int IN_W         = ((3 * CURRENT_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // current_a, current_b, current_c
  input  logic [IN_W-1:0]             s_tdata,
  // kind
  input  logic [1:0]                  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // duty_a, duty_b, duty_c, drive_enable, running, found, done_pulse, sector, pattern
  output logic [rppd_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rppd_pkg::*;

  logic [15:0] pwm_period;
  logic [15:0] duty_fraction;
  logic [15:0] hold_ticks;
  logic        wr_en;
  cmd_t        cmd;
  stat_t       stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period    <= PWM_PERIOD_RST;
      duty_fraction <= DUTY_FRACTION_RST;
      hold_ticks    <= HOLD_TICKS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PWM_PERIOD:    pwm_period    <= pwdata[15:0];
        REG_DUTY_FRACTION: duty_fraction <= pwdata[15:0];
        REG_HOLD_TICKS:    hold_ticks    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PWM_PERIOD:    prdata = {16'd0, pwm_period};
      REG_DUTY_FRACTION: prdata = {16'd0, duty_fraction};
      REG_HOLD_TICKS:    prdata = {16'd0, hold_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  rppd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rppd_datapath #(
    .VOTES        (VOTES),
    .CURRENT_BITS (CURRENT_BITS),
    .IN_W         (IN_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .pwm_period    (pwm_period),
    .duty_fraction (duty_fraction),
    .hold_ticks    (hold_ticks),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .cmd           (cmd),
    .stat          (stat),
    .m_tdata       (m_tdata)
  );

endmodule

// File: sv/rppd_ctrl.sv
// Controller for the rotor position pulse detector.
// Sequences load, step, vote, count, judge and output; uses rppd_pkg.
module rppd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  rppd_pkg::stat_t stat,
  output rppd_pkg::cmd_t  cmd
);
  import rppd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_PAT,
    ST_COUNT,
    ST_JUDGE,
    ST_OUT
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && s_tvalid;
    cmd.step     = (state == ST_STEP);
    cmd.pat      = (state == ST_PAT);
    cmd.cnt_step = (state == ST_COUNT);
    cmd.judge    = (state == ST_JUDGE);
    cmd.out_load = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (m_tready && !cmd.out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          state <= stat.pat_req ? ST_PAT : ST_OUT;
        end
        ST_PAT: begin
          state <= stat.last_vote ? ST_COUNT : ST_OUT;
        end
        ST_COUNT: begin
          if (stat.cnt_last) begin
            state <= ST_JUDGE;
          end
        end
        ST_JUDGE: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/rppd_datapath.sv
// Datapath for the rotor position pulse detector.
// Step state, current and vote stores, vote counters, duty multiply, output word.
// Uses rppd_pkg; driven by rppd_ctrl commands.
module rppd_datapath #(
  parameter int VOTES        = rppd_pkg::VOTES_DEF,
  parameter int CURRENT_BITS = rppd_pkg::CURRENT_BITS_DEF,
  parameter int IN_W         = ((3 * CURRENT_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [15:0]              pwm_period,
  input  logic [15:0]              duty_fraction,
  input  logic [15:0]              hold_ticks,
  input  logic [IN_W-1:0]          s_tdata,
  input  logic [1:0]               s_tuser,
  input  rppd_pkg::cmd_t           cmd,
  output rppd_pkg::stat_t          stat,
  output logic [rppd_pkg::OUT_W-1:0] m_tdata
);
  import rppd_pkg::*;

  localparam int CB    = CURRENT_BITS;
  localparam int VL_W  = $clog2(VOTES + 1);
  localparam int IDX_W = (VOTES > 1) ? $clog2(VOTES) : 1;
  localparam int HALF  = VOTES / 2;

  logic [1:0]       kind;
  logic [CB-1:0]    cur [3];
  logic             run_flag;
  logic [16:0]      hold_count;
  logic [2:0]       step_code;
  logic [2:0]       last_vector;
  logic [2:0]       next_vector;
  logic [CB-1:0]    store [6];
  logic [2:0]       votes [VOTES];
  logic [VL_W-1:0]  votes_left;
  logic             found_flag;
  logic [2:0]       sector_reg;
  logic [2:0]       pattern_reg;
  logic             done_flag;
  logic [VL_W-1:0]  cnt [8];
  logic [IDX_W-1:0] idx;
  logic [31:0]      prod;

  logic [16:0]      hold_reload;
  logic             acts;
  logic [2:0]       v_on;
  logic [CB-1:0]    raw;
  logic [CB-1:0]    mag;
  logic [2:0]       pat;
  logic [VL_W-1:0]  vl_eff;
  logic [VL_W-1:0]  vl_new;
  logic             hit;
  logic [2:0]       win;
  logic [2:0]       mask;
  logic [15:0]      duty;
  logic [15:0]      pm1;

  assign hold_reload = {1'b0, hold_ticks} + 17'd1;
  assign acts        = run_flag && (hold_count > {1'b0, hold_ticks});
  assign v_on        = (step_code == VEC_ALT) ? VEC_ONE : step_code;
  assign raw         = cur[vec_phase(last_vector)];
  assign mag         = raw[CB-1] ? (~raw + {{(CB-1){1'b0}}, 1'b1}) : raw;
  assign pat         = {store[4] > store[5], store[2] > store[3], store[0] > store[1]};
  assign vl_eff      = ((votes_left == '0) || (votes_left > VL_W'(VOTES))) ?
                       VL_W'(VOTES) : votes_left;
  assign vl_new      = vl_eff - {{(VL_W-1){1'b0}}, 1'b1};

  assign stat.pat_req   = (kind == KIND_TICK) && acts && (step_code == VEC_OFF) &&
                          (last_vector == VEC_LAST);
  assign stat.last_vote = (vl_new == '0);
  assign stat.cnt_last  = (idx == IDX_W'(VOTES - 1));

  always_comb begin
    hit = 1'b0;
    win = 3'd0;
    for (int p = 7; p >= 0; p--) begin
      if ((cnt[p] > VL_W'(HALF)) && pat_ok(3'(p))) begin
        hit = 1'b1;
        win = 3'(p);
      end
    end
  end

  assign pm1  = pwm_period - 16'd1;
  assign mask = run_flag ? vec_mask(last_vector) : 3'd0;
  assign duty = (pwm_period != 16'd0) ? prod[31:16] : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag    <= 1'b0;
      hold_count  <= '0;
      step_code   <= VEC_ONE;
      last_vector <= VEC_OFF;
      next_vector <= VEC_OFF;
      for (int i = 0; i < 6; i++) begin
        store[i] <= '0;
      end
      votes_left  <= VL_W'(VOTES);
      found_flag  <= 1'b0;
      sector_reg  <= 3'd0;
      pattern_reg <= 3'd0;
      done_flag   <= 1'b0;
    end else begin
      if (cmd.load) begin
        done_flag <= 1'b0;
      end
      if (cmd.step) begin
        case (kind)
          KIND_TICK: begin
            if (acts) begin
              hold_count <= '0;
              if (step_code == VEC_OFF) begin
                step_code   <= next_vector;
                last_vector <= VEC_OFF;
                if (last_vector != VEC_OFF) begin
                  store[vec_slot(last_vector)] <= mag;
                end
              end else begin
                last_vector <= v_on;
                next_vector <= vec_next(v_on);
                step_code   <= VEC_OFF;
              end
            end else if (run_flag) begin
              hold_count <= hold_count + 17'd1;
            end
          end
          KIND_START: begin
            found_flag  <= 1'b0;
            step_code   <= VEC_ONE;
            next_vector <= VEC_OFF;
            votes_left  <= VL_W'(VOTES);
            hold_count  <= hold_reload;
            run_flag    <= 1'b1;
          end
          KIND_STOP: begin
            run_flag    <= 1'b0;
            step_code   <= VEC_ONE;
            next_vector <= VEC_OFF;
            hold_count  <= hold_reload;
            last_vector <= VEC_OFF;
          end
          default: begin
            found_flag  <= 1'b0;
            sector_reg  <= 3'd0;
            pattern_reg <= 3'd0;
          end
        endcase
      end
      if (cmd.pat) begin
        votes_left <= vl_new;
      end
      if (cmd.judge) begin
        if (hit) begin
          found_flag  <= 1'b1;
          sector_reg  <= pat_sector(win);
          pattern_reg <= win;
          done_flag   <= 1'b1;
          run_flag    <= 1'b0;
          step_code   <= VEC_ONE;
          next_vector <= VEC_OFF;
          hold_count  <= hold_reload;
          last_vector <= VEC_OFF;
        end else begin
          votes_left <= VL_W'(VOTES);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= {16'd0, pm1} * {16'd0, duty_fraction};
    if (cmd.load) begin
      kind <= s_tuser;
      for (int i = 0; i < 3; i++) begin
        cur[i] <= s_tdata[i*CB +: CB];
      end
    end
    if (cmd.pat) begin
      votes[vl_new[IDX_W-1:0]] <= pat;
      for (int p = 0; p < 8; p++) begin
        cnt[p] <= '0;
      end
      idx <= '0;
    end
    if (cmd.cnt_step) begin
      cnt[votes[idx]] <= cnt[votes[idx]] + {{(VL_W-1){1'b0}}, 1'b1};
      idx <= idx + {{(IDX_W-1){1'b0}}, 1'b1};
    end
    if (cmd.out_load) begin
      m_tdata <= {6'd0, pattern_reg, sector_reg, done_flag, found_flag, run_flag,
                  |mask,
                  mask[2] ? duty : 16'd0,
                  mask[1] ? duty : 16'd0,
                  mask[0] ? duty : 16'd0};
    end
  end

endmodule
